FILE: rtl/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg: shared types and constants of the cursor array list
// Operation and status codes, field widths and the command that the control
// unit broadcasts to the row of entry cells.
// ----------------------------------------------------------------------------
package cal_pkg;

    localparam int CAL_CAPACITY     = 256;
    localparam int CAL_DATA_WIDTH   = 32;
    localparam int CAL_ADDR_MAX_W   = 12;   // enough for the largest capacity
    localparam int CAL_DATA_MAX_W   = 64;   // widest stored element

    localparam int MODE_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;
    localparam int CURSOR_W = 8;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_BEFORE = 4'd0,
        MODE_INS_AFTER  = 4'd1,
        MODE_DELETE     = 4'd2,
        MODE_PREV       = 4'd3,
        MODE_NEXT       = 4'd4,
        MODE_START      = 4'd5,
        MODE_END        = 4'd6,
        MODE_RD_IDX     = 4'd7,
        MODE_WR_IDX     = 4'd8,
        MODE_RD_CUR     = 4'd9,
        MODE_WR_CUR     = 4'd10
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_RANGE = 3'd2,
        ST_FULL  = 3'd3,
        ST_EDGE  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_WR   = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic                      rd_load;   // snapshot entries into read chain
        logic                      rd_shift;  // move read chain one cell down
        logic [CAL_ADDR_MAX_W-1:0] addr;
        logic [CAL_DATA_MAX_W-1:0] value;
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

FILE: rtl/cursor_array_list.sv
// ----------------------------------------------------------------------------
// cursor_array_list: ordered list store with a cursor
// Usage notes:
// Each input transaction on s_axis carries one operation (insert before or
// after the cursor, delete, cursor moves, read or write by index or at the
// cursor). Each operation produces exactly one result transaction on m_axis
// with status, data read, element count and cursor after the operation.
// Entries sit in a row of cells; inserts and deletes shift every entry from
// the addressed place on by one place.
// Every operation but the reads shows its result in the cycle after it is
// accepted. A read snapshots the row into a read chain that moves one cell per
// cycle toward cell 0 until the addressed place reaches it; no new transaction
// is accepted before the read result is registered, so that chain sets the
// read throughput. Other operations sustain one per cycle while results are taken.
// The result register lets a new transaction be accepted while the previous
// result is taken in the same cycle; when m_axis_tready stays low the result
// is held and s_axis_tready drops.
// Reset (synchronous, active low) empties the list and puts the cursor at 0;
// entry contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module cursor_array_list
    import cal_pkg::*;
#(
    parameter int CAPACITY   = CAL_CAPACITY,
    parameter int DATA_WIDTH = CAL_DATA_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // mode[3:0], value[35:4], index[43:36]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // status[2:0], data[34:3],
                                                  // count[43:35], cursor[51:44]
);

    t_cell_cmd             cmd;
    logic [DATA_WIDTH-1:0] entry [CAPACITY];
    logic [DATA_WIDTH-1:0] col   [CAPACITY];
    logic [STATUS_W-1:0]   status;
    logic [VALUE_W-1:0]    data;
    logic [COUNT_W-1:0]    count;
    logic [CURSOR_W-1:0]   cursor;

    cal_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tdata[3:0]),
        .i_value     (s_axis_tdata[35:4]),
        .i_index     (s_axis_tdata[43:36]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_data      (data),
        .o_count     (count),
        .o_cursor    (cursor),
        .o_cmd       (cmd),
        .i_col       (col[0])
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;
        logic [DATA_WIDTH-1:0] col_right;

        if (k == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = entry[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right     = '0;
            assign col_right = '0;
        end else begin : g_mid_r
            assign right     = entry[k+1];
            assign col_right = col[k+1];
        end

        cal_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_left      (left),
            .i_right     (right),
            .i_col_right (col_right),
            .o_entry     (entry[k]),
            .o_col       (col[k])
        );
    end

    assign m_axis_tdata = {4'd0, cursor, count, data, status};

endmodule

FILE: rtl/cal_cell.sv
// ----------------------------------------------------------------------------
// cal_cell: one entry of the list
// Holds one element and one read-chain stage. Takes its left or right
// neighbor on insert or delete, the broadcast value on a write or an insert at its own place.
// ----------------------------------------------------------------------------
module cal_cell
    import cal_pkg::*;
#(
    parameter int DATA_WIDTH = CAL_DATA_WIDTH,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_col_right,
    output logic [DATA_WIDTH-1:0] o_entry,
    output logic [DATA_WIDTH-1:0] o_col
);

    localparam logic [CAL_ADDR_MAX_W-1:0] MY_ADDR = CAL_ADDR_MAX_W'(IDX);

    logic [DATA_WIDTH-1:0] r_entry;
    logic [DATA_WIDTH-1:0] r_col;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_INS: begin
                if (MY_ADDR > i_cmd.addr) begin
                    r_entry <= i_left;
                end else if (MY_ADDR == i_cmd.addr) begin
                    r_entry <= i_cmd.value[DATA_WIDTH-1:0];
                end
            end
            CELL_DEL: begin
                if (MY_ADDR >= i_cmd.addr) begin
                    r_entry <= i_right;
                end
            end
            CELL_WR: begin
                if (MY_ADDR == i_cmd.addr) begin
                    r_entry <= i_cmd.value[DATA_WIDTH-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_load) begin
            r_col <= r_entry;
        end else if (i_cmd.rd_shift) begin
            r_col <= i_col_right;
        end
    end

    assign o_entry = r_entry;
    assign o_col   = r_col;

endmodule

FILE: rtl/cal_ctrl.sv
// ----------------------------------------------------------------------------
// cal_ctrl: control unit of the cursor array list
// Decodes each operation, keeps count and cursor, drives the cell row and
// holds the result register toward the output stream.
// ----------------------------------------------------------------------------
module cal_ctrl
    import cal_pkg::*;
#(
    parameter int CAPACITY   = CAL_CAPACITY,
    parameter int DATA_WIDTH = CAL_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic [INDEX_W-1:0]    i_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [VALUE_W-1:0]    o_data,
    output logic [COUNT_W-1:0]    o_count,
    output logic [CURSOR_W-1:0]   o_cursor,
    output t_cell_cmd             o_cmd,
    input  logic [DATA_WIDTH-1:0] i_col
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > INDEX_W) ? LW : INDEX_W;
    localparam logic [LW-1:0] FULL_LEN = LW'(CAPACITY);

    t_state r_state, n_state;
    logic [LW-1:0]       r_len, n_len;
    logic [AW-1:0]       r_pos, n_pos;
    logic [AW-1:0]       r_cnt, n_cnt;
    logic                r_ovalid, n_ovalid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VALUE_W-1:0]  r_data, n_data;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [CURSOR_W-1:0] r_cursor, n_cursor;

    t_mode              mode;
    logic               accept;
    logic               out_free;
    logic               empty;
    logic               full;
    logic               idx_ok;
    logic               rd_go;
    logic signed [63:0] val64;
    logic signed [63:0] col64;

    assign mode     = t_mode'(i_mode);
    assign out_free = !r_ovalid || i_out_ready;
    assign accept   = i_in_valid && o_in_ready;
    assign empty    = (r_len == '0);
    assign full     = (r_len == FULL_LEN);
    assign idx_ok   = CW'(i_index) < CW'(r_len);
    assign rd_go    = ((mode == MODE_RD_IDX) && idx_ok) || ((mode == MODE_RD_CUR) && !empty);
    assign val64    = 64'(signed'(i_value));
    assign col64    = 64'(signed'(i_col));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && rd_go) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if ((r_cnt == '0) && out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        logic    fin;
        t_status st;
        fin        = 1'b0;
        st         = ST_OK;
        n_len      = r_len;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_status   = r_status;
        n_data     = r_data;
        n_count    = r_count;
        n_cursor   = r_cursor;
        o_in_ready = (r_state == S_IDLE) && out_free;
        o_cmd          = '0;
        o_cmd.op       = CELL_HOLD;
        o_cmd.value    = val64;

        if (accept) begin
            fin = 1'b1;
            case (mode)
                MODE_INS_BEFORE, MODE_INS_AFTER: begin
                    if (full) begin
                        st = ST_FULL;
                    end else if (empty) begin
                        o_cmd.op   = CELL_INS;
                        o_cmd.addr = '0;
                        n_len      = LW'(1);
                        n_pos      = '0;
                    end else if (mode == MODE_INS_BEFORE) begin
                        o_cmd.op   = CELL_INS;
                        o_cmd.addr = CAL_ADDR_MAX_W'(r_pos);
                        n_pos      = r_pos + AW'(1);
                        n_len      = r_len + LW'(1);
                    end else begin
                        o_cmd.op   = CELL_INS;
                        o_cmd.addr = CAL_ADDR_MAX_W'(r_pos + AW'(1));
                        n_len      = r_len + LW'(1);
                    end
                end
                MODE_DELETE: begin
                    if (empty) begin
                        st = ST_EMPTY;
                    end else begin
                        o_cmd.op   = CELL_DEL;
                        o_cmd.addr = CAL_ADDR_MAX_W'(r_pos);
                        n_len      = r_len - LW'(1);
                        if (r_len == LW'(1)) begin
                            n_pos = '0;
                        end else if ((LW'(r_pos) == r_len - LW'(1)) && (r_pos != '0)) begin
                            // cursor on the last entry steps back
                            n_pos = r_pos - AW'(1);
                        end
                    end
                end
                MODE_PREV: begin
                    if (empty) begin
                        st = ST_EMPTY;
                    end else if (r_pos == '0) begin
                        st = ST_EDGE;
                    end else begin
                        n_pos = r_pos - AW'(1);
                    end
                end
                MODE_NEXT: begin
                    if (empty) begin
                        st = ST_EMPTY;
                    end else if ((LW'(r_pos) + LW'(1)) >= r_len) begin
                        st = ST_EDGE;
                    end else begin
                        n_pos = r_pos + AW'(1);
                    end
                end
                MODE_START: begin
                    if (empty) begin
                        st = ST_EMPTY;
                    end else begin
                        n_pos = '0;
                    end
                end
                MODE_END: begin
                    if (empty) begin
                        st = ST_EMPTY;
                    end else begin
                        n_pos = AW'(r_len - LW'(1));
                    end
                end
                MODE_RD_IDX: begin
                    if (!idx_ok) begin
                        st = ST_RANGE;
                    end else begin
                        fin           = 1'b0;
                        o_cmd.rd_load = 1'b1;
                        n_cnt         = AW'(i_index);
                    end
                end
                MODE_WR_IDX: begin
                    if (!idx_ok) begin
                        st = ST_RANGE;
                    end else begin
                        o_cmd.op   = CELL_WR;
                        o_cmd.addr = CAL_ADDR_MAX_W'(AW'(i_index));
                    end
                end
                MODE_RD_CUR: begin
                    if (empty) begin
                        st = ST_EMPTY;
                    end else begin
                        fin           = 1'b0;
                        o_cmd.rd_load = 1'b1;
                        n_cnt         = r_pos;
                    end
                end
                MODE_WR_CUR: begin
                    if (empty) begin
                        st = ST_EMPTY;
                    end else begin
                        o_cmd.op   = CELL_WR;
                        o_cmd.addr = CAL_ADDR_MAX_W'(r_pos);
                    end
                end
                default: begin
                end
            endcase
            if (fin) begin
                n_ovalid = 1'b1;
                n_status = st;
                n_data   = '0;
                n_count  = COUNT_W'(n_len);
                n_cursor = CURSOR_W'(n_pos);
            end
        end else if (r_state == S_READ) begin
            // the read chain brings the addressed entry down to cell 0
            if (r_cnt != '0) begin
                o_cmd.rd_shift = 1'b1;
                n_cnt          = r_cnt - AW'(1);
            end else if (out_free) begin
                n_ovalid = 1'b1;
                n_status = ST_OK;
                n_data   = col64[VALUE_W-1:0];
                n_count  = COUNT_W'(r_len);
                n_cursor = CURSOR_W'(r_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_data   <= n_data;
        r_count  <= n_count;
        r_cursor <= n_cursor;
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_count     = r_count;
    assign o_cursor    = r_cursor;

endmodule

FILE: dv/cursor_array_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_array_list_tb: self-checking bench for the cursor array list
// A driver sends list operations on s_axis and a scoreboard tracks its own
// copy of the list and the cursor. Each reply on m_axis is checked field by
// field against the oldest pending prediction. Directed corner cases come
// first. A random mix follows under three idle patterns, with one long
// receiver hold-off and one fill to capacity followed by a full drain.
// ----------------------------------------------------------------------------
module cursor_array_list_tb
    import cal_pkg::*;
;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 5;
    localparam int ITEMS_PER_PHASE = 340;
    localparam int MAX_TARGET      = 24;     // keeps most lists short so reads stay fast
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 300;    // outlasts a read of the top place
    localparam int INDEX_MAX       = 2**INDEX_W - 1;
    localparam int MODE_MAX        = 2**MODE_W - 1;

    // first code past the defined operations
    localparam logic [MODE_W-1:0] MODE_UNUSED = MODE_W'(int'(MODE_WR_CUR) + 1);

    // m_axis_tdata layout
    localparam int ST_LSB  = 0;
    localparam int DAT_LSB = ST_LSB + STATUS_W;
    localparam int CNT_LSB = DAT_LSB + VALUE_W;
    localparam int CUR_LSB = CNT_LSB + COUNT_W;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic [MODE_W-1:0]  mode;
    } t_list_op;

    typedef struct packed {
        t_status             status;
        logic [VALUE_W-1:0]  data;
        logic [COUNT_W-1:0]  count;
        logic [CURSOR_W-1:0] cursor;
    } t_list_reply;

    class list_scoreboard;
        logic [VALUE_W-1:0] cells [CAL_CAPACITY];
        int                 length;
        int                 cursor;
        t_list_reply        replies_due [$];
        int                 n_errors;

        function new();
            length   = 0;
            cursor   = 0;
            n_errors = 0;
        endfunction

        // Apply one accepted operation to the shadow list and queue its reply.
        function void apply_op(t_list_op op);
            t_list_reply r;
            int i;
            r.status = ST_OK;
            r.data   = '0;
            case (op.mode)
                MODE_INS_BEFORE, MODE_INS_AFTER: begin
                    if (length >= CAL_CAPACITY) begin
                        r.status = ST_FULL;
                    end else if (length == 0) begin
                        cells[0] = op.value;
                        length   = 1;
                        cursor   = 0;
                    end else if (op.mode == MODE_INS_BEFORE) begin
                        for (i = length; i > cursor; i--) cells[i] = cells[i-1];
                        cells[cursor] = op.value;
                        cursor++;
                        length++;
                    end else begin
                        for (i = length; i > cursor + 1; i--) cells[i] = cells[i-1];
                        cells[cursor+1] = op.value;
                        length++;
                    end
                end
                MODE_DELETE: begin
                    if (length == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        for (i = cursor; i + 1 < length; i++) cells[i] = cells[i+1];
                        if (cursor == length - 1 && cursor > 0) cursor--;
                        length--;
                        if (length == 0) cursor = 0;
                    end
                end
                MODE_PREV: begin
                    if (length == 0)      r.status = ST_EMPTY;
                    else if (cursor == 0) r.status = ST_EDGE;
                    else                  cursor--;
                end
                MODE_NEXT: begin
                    if (length == 0)                r.status = ST_EMPTY;
                    else if (cursor + 1 >= length)  r.status = ST_EDGE;
                    else                            cursor++;
                end
                MODE_START: begin
                    if (length == 0) r.status = ST_EMPTY;
                    else             cursor = 0;
                end
                MODE_END: begin
                    if (length == 0) r.status = ST_EMPTY;
                    else             cursor = length - 1;
                end
                MODE_RD_IDX: begin
                    if (op.index >= length) r.status = ST_RANGE;
                    else                    r.data = cells[op.index];
                end
                MODE_WR_IDX: begin
                    if (op.index >= length) r.status = ST_RANGE;
                    else                    cells[op.index] = op.value;
                end
                MODE_RD_CUR: begin
                    if (length == 0) r.status = ST_EMPTY;
                    else             r.data = cells[cursor];
                end
                MODE_WR_CUR: begin
                    if (length == 0) r.status = ST_EMPTY;
                    else             cells[cursor] = op.value;
                end
                default: ;  // unused codes leave everything alone
            endcase
            r.count  = COUNT_W'(length);
            r.cursor = CURSOR_W'(cursor);
            replies_due.push_back(r);
        endfunction

        function void compare_field(string field, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, field, want, got);
                n_errors++;
            end
        endfunction

        function void check_reply(logic [OUT_TDATA_W-1:0] tdata);
            t_list_reply want;
            if (replies_due.size() == 0) begin
                $display("%0t: reply with none pending: expected nothing, actual %0h",
                         $time, tdata);
                n_errors++;
                return;
            end
            want = replies_due.pop_front();
            compare_field("status", VALUE_W'(want.status), VALUE_W'(tdata[ST_LSB +: STATUS_W]));
            compare_field("data", want.data, tdata[DAT_LSB +: VALUE_W]);
            compare_field("count", VALUE_W'(want.count), VALUE_W'(tdata[CNT_LSB +: COUNT_W]));
            compare_field("cursor", VALUE_W'(want.cursor),
                          VALUE_W'(tdata[CUR_LSB +: CURSOR_W]));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // mode[3:0], value[35:4], index[43:36]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // status[2:0], data[34:3],
                                            // count[43:35], cursor[51:44]

    list_scoreboard sb;
    int             tx_idle_pct;
    int             rx_idle_pct;
    logic           rx_hold_req = 1'b0;
    int             stall_cycles = 0;

    cursor_array_list u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Offer one operation, wait for its transaction, then hand it to the scoreboard.
    task automatic send_op(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                           logic [INDEX_W-1:0] index);
        t_list_op op;
        op.mode  = mode;
        op.value = value;
        op.index = index;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(op);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.apply_op(op);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0:       return {1'b1, {(VALUE_W-1){1'b0}}};
                1:       return {1'b0, {(VALUE_W-1){1'b1}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom();
    endfunction

    // Random operation; inserts and deletes lean toward a target length.
    task automatic send_random_op(int target);
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] index;
        int pick;
        int ins_w;
        int del_w;
        ins_w = (sb.length < target) ? 32 : 10;
        del_w = (sb.length < target) ? 8 : 28;
        pick  = $urandom_range(99);
        if (pick < 3)
            mode = MODE_W'($urandom_range(MODE_MAX, int'(MODE_UNUSED)));
        else if (pick < 3 + ins_w)
            mode = $urandom_range(1) ? MODE_INS_AFTER : MODE_INS_BEFORE;
        else if (pick < 3 + ins_w + del_w)
            mode = MODE_DELETE;
        else
            mode = MODE_W'($urandom_range(int'(MODE_WR_CUR), int'(MODE_PREV)));
        if (sb.length > 0 && $urandom_range(99) < 80)
            index = INDEX_W'($urandom_range(sb.length - 1, 0));
        else
            index = INDEX_W'($urandom_range(INDEX_MAX, 0));
        send_op(mode, pick_value(), index);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                repeat (RX_HOLD_CYCLES) begin
                    m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int phase;
        int n;
        int target;
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_idle_pct   = 35;
        rx_idle_pct   = 79;
        target        = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: everything on an empty list, then a short list walked end to end.
        send_op(MODE_RD_CUR, '0, '0);
        send_op(MODE_DELETE, '0, '0);
        send_op(MODE_PREV, '0, '0);
        send_op(MODE_NEXT, '0, '0);
        send_op(MODE_START, '0, '0);
        send_op(MODE_END, '0, '0);
        send_op(MODE_WR_CUR, '1, '0);
        send_op(MODE_RD_IDX, '0, '0);
        send_op(MODE_WR_IDX, '1, '0);
        send_op(MODE_INS_AFTER, {1'b0, {(VALUE_W-1){1'b1}}}, '0);
        send_op(MODE_INS_BEFORE, {1'b1, {(VALUE_W-1){1'b0}}}, '0);
        send_op(MODE_INS_AFTER, '0, '0);
        send_op(MODE_INS_BEFORE, '1, '0);
        send_op(MODE_PREV, '0, '0);
        send_op(MODE_PREV, '0, '0);
        send_op(MODE_PREV, '0, '0);      // cursor already at the first entry
        send_op(MODE_END, '0, '0);
        send_op(MODE_NEXT, '0, '0);      // cursor already at the last entry
        send_op(MODE_RD_IDX, '0, INDEX_W'(INDEX_MAX));
        send_op(MODE_WR_IDX, '1, INDEX_W'(INDEX_MAX));
        send_op(MODE_WR_IDX, 32'h5555_5555, 8'd3);
        send_op(MODE_RD_IDX, '0, 8'd3);
        send_op(MODE_WR_CUR, 32'haaaa_aaaa, '0);
        send_op(MODE_RD_CUR, '0, '0);
        send_op(MODE_UNUSED, '0, '0);
        send_op(MODE_DELETE, '0, '0);    // delete on the last entry steps back

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 35; rx_idle_pct = 79; end
                1:       begin tx_idle_pct = 79; rx_idle_pct = 35; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            // Long receiver hold-off while the sender keeps offering.
            if (phase == 0) rx_hold_req = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 60 == 0) target = $urandom_range(MAX_TARGET, 1);
                send_random_op(target);
            end
            if (phase == 1) begin
                // Fill to capacity, poke the full list, then drain it to empty.
                while (sb.length < CAL_CAPACITY)
                    send_op($urandom_range(1) ? MODE_INS_AFTER : MODE_INS_BEFORE,
                            $urandom(), INDEX_W'($urandom()));
                send_op(MODE_INS_BEFORE, $urandom(), '0);
                send_op(MODE_INS_AFTER, $urandom(), '0);
                send_op(MODE_RD_IDX, '0, INDEX_W'(INDEX_MAX));
                send_op(MODE_WR_IDX, $urandom(), INDEX_W'(INDEX_MAX));
                send_op(MODE_RD_IDX, '0, INDEX_W'(INDEX_MAX));
                send_op(MODE_END, '0, '0);
                send_op(MODE_NEXT, '0, '0);
                send_op(MODE_RD_CUR, '0, '0);
                send_op(MODE_START, '0, '0);
                send_op(MODE_PREV, '0, '0);
                send_op(MODE_WR_CUR, $urandom(), '0);
                send_op(MODE_RD_IDX, '0, '0);
                while (sb.length > 0) begin
                    if ($urandom_range(9) == 0)
                        send_op(MODE_W'($urandom_range(int'(MODE_END), int'(MODE_PREV))),
                                '0, '0);
                    else
                        send_op(MODE_DELETE, '0, '0);
                end
                send_op(MODE_DELETE, '0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cal_pkg.sv
rtl/cal_cell.sv
rtl/cal_ctrl.sv
rtl/cursor_array_list.sv
dv/cursor_array_list_tb.sv
